>>> rtl/core/accel_capture_peak_tracker_defines.svh
`ifndef ACCEL_CAPTURE_PEAK_TRACKER_DEFINES_SVH
`define ACCEL_CAPTURE_PEAK_TRACKER_DEFINES_SVH

// same-cycle implication check
`define ACPT_CHECK_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication check
`define ACPT_CHECK_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/acpt_pkg.sv
`timescale 1ns / 1ps

package acpt_pkg;

   localparam int NUM_AXES     = 3;
   localparam int AXIS_W       = 8;
   localparam int PEAK_W       = 7;
   localparam int PROD_W       = 18;
   localparam int COUNTS_SHIFT = 6;
   localparam int MG_W         = PROD_W - COUNTS_SHIFT;
   localparam int MG_SUM_W     = 14;
   localparam int PEAK_MG_W    = 13;
   localparam int MG_PER_G     = 1000;
   localparam int MG_PEAK_MAX  = 5952;

   typedef struct packed {
      logic [7:0] accel_x;
      logic [7:0] accel_y;
      logic [7:0] accel_z;
      logic       last_sample;
   } acpt_req_type;

   typedef struct packed {
      logic [6:0]        peak_x;
      logic [6:0]        peak_y;
      logic [6:0]        peak_z;
      logic signed [7:0] trough_x;
      logic signed [7:0] trough_y;
      logic signed [7:0] trough_z;
      logic [12:0]       peak_milli_g;
   } acpt_rsp_type;

   typedef struct packed {
      logic load;
      logic last;
   } acpt_lane_ctrl_type;

   typedef struct packed {
      logic [PEAK_W-1:0]        hi;
      logic signed [AXIS_W-1:0] lo;
      logic signed [MG_W-1:0]   mg;
   } acpt_lane_out_type;

endpackage

>>> rtl/core/acpt_lane.sv
`timescale 1ns / 1ps

module acpt_lane (
   input  logic                          clock,
   input  logic                          reset,
   input  acpt_pkg::acpt_lane_ctrl_type  ctrl,
   input  logic [acpt_pkg::AXIS_W-1:0]   sample,
   output acpt_pkg::acpt_lane_out_type   result
);
   import acpt_pkg::*;

   localparam logic signed [PROD_W-1:0] ROUND_BIAS = PROD_W'((1 << COUNTS_SHIFT) - 1);

   logic signed [AXIS_W-1:0] value;
   logic [PEAK_W-1:0]        hi_ff, hi_in, hi_upd;
   logic signed [AXIS_W-1:0] lo_ff, lo_in, lo_upd;
   logic signed [PROD_W-1:0] prod;
   logic signed [PROD_W-1:0] biased;
   acpt_lane_out_type        result_ff, result_in;

   assign value = $signed(sample);

   always_comb begin
      hi_upd = hi_ff;
      lo_upd = lo_ff;
      if (value > $signed({1'b0, hi_ff})) begin
         hi_upd = value[PEAK_W-1:0];
      end
      if (value < lo_ff) begin
         lo_upd = value;
      end
      prod   = PROD_W'(value * MG_PER_G);
      // truncate toward zero: bias negative products before the shift
      biased = prod + (prod[PROD_W-1] ? ROUND_BIAS : '0);

      result_in.hi = hi_upd;
      result_in.lo = lo_upd;
      result_in.mg = biased[PROD_W-1:COUNTS_SHIFT];

      hi_in = hi_ff;
      lo_in = lo_ff;
      if (ctrl.load) begin
         hi_in = ctrl.last ? '0 : hi_upd;
         lo_in = ctrl.last ? '0 : lo_upd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hi_ff <= '0;
         lo_ff <= '0;
      end else begin
         hi_ff <= hi_in;
         lo_ff <= lo_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule

>>> rtl/core/acpt_merge.sv
`timescale 1ns / 1ps

module acpt_merge (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          take,
   input  logic                          last,
   input  acpt_pkg::acpt_lane_out_type   lanes [acpt_pkg::NUM_AXES],
   output logic                          take_ready,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output acpt_pkg::acpt_rsp_type        rsp_data
);
   import acpt_pkg::*;

   logic signed [MG_SUM_W-1:0] g_sum;
   logic [PEAK_MG_W-1:0]       peak_ff, peak_in, peak_upd;
   logic                       rsp_valid_ff, rsp_valid_in;
   acpt_rsp_type               rsp_ff, rsp_in;

   assign take_ready = !last || !rsp_valid_ff || rsp_ready;

   always_comb begin
      g_sum = MG_SUM_W'(lanes[0].mg) + MG_SUM_W'(lanes[1].mg) + MG_SUM_W'(lanes[2].mg);
      peak_upd = peak_ff;
      if (g_sum > $signed({1'b0, peak_ff})) begin
         peak_upd = g_sum[PEAK_MG_W-1:0];
      end

      rsp_in.peak_x       = lanes[0].hi;
      rsp_in.peak_y       = lanes[1].hi;
      rsp_in.peak_z       = lanes[2].hi;
      rsp_in.trough_x     = lanes[0].lo;
      rsp_in.trough_y     = lanes[1].lo;
      rsp_in.trough_z     = lanes[2].lo;
      rsp_in.peak_milli_g = peak_upd;

      peak_in      = peak_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (take) begin
         peak_in = last ? '0 : peak_upd;
         if (last) begin
            rsp_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         peak_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         peak_ff      <= peak_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take && last) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

>>> rtl/core/accel_capture_peak_tracker.sv
// path: a last-flagged transaction passes the lane result registers, then the merge response
// register before rsp_valid rises; merge_ready can hold it between the two
// throughput: one sample per cycle when not stalled; three axis lanes and one merge stage, fully pipelined
// a transaction stalls only while a finished result waits and the next one in flight is last
// reset clears all extremes, the milli-g peak and both pipeline valid flags
`timescale 1ns / 1ps
`include "accel_capture_peak_tracker_defines.svh"

module accel_capture_peak_tracker (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  acpt_pkg::acpt_req_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output acpt_pkg::acpt_rsp_type rsp_data
);
   import acpt_pkg::*;

   logic                     req_accept;
   logic                     s1_valid_ff, s1_valid_in;
   logic                     s1_last_ff;
   logic                     s1_take;
   logic                     merge_ready;
   acpt_lane_ctrl_type       lane_ctrl;
   logic [AXIS_W-1:0]        samples [NUM_AXES];
   acpt_lane_out_type        lane_res [NUM_AXES];

   assign req_ready  = !s1_valid_ff || merge_ready;
   assign req_accept = req_valid && req_ready;
   assign s1_take    = s1_valid_ff && merge_ready;

   assign lane_ctrl.load = req_accept;
   assign lane_ctrl.last = req_data.last_sample;

   assign samples[0] = req_data.accel_x;
   assign samples[1] = req_data.accel_y;
   assign samples[2] = req_data.accel_z;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_take) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_last_ff <= req_data.last_sample;
      end
   end

   for (genvar i = 0; i < NUM_AXES; i++) begin : g_lane
      acpt_lane u_lane (
         .clock  (clock),
         .reset  (reset),
         .ctrl   (lane_ctrl),
         .sample (samples[i]),
         .result (lane_res[i])
      );
   end

   acpt_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .take       (s1_take),
      .last       (s1_last_ff),
      .lanes      (lane_res),
      .take_ready (merge_ready),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

   `ACPT_CHECK_NOW(a_ready_only_on_backpressure, clock, reset, !req_ready,
      rsp_valid && !rsp_ready && s1_valid_ff && s1_last_ff,
      "input stalled without output backpressure")
   `ACPT_CHECK_NEXT(a_last_yields_result, clock, reset, s1_take && s1_last_ff,
      rsp_valid, "last transaction produced no result")
   `ACPT_CHECK_NOW(a_peak_in_range, clock, reset, rsp_valid,
      rsp_data.peak_milli_g <= PEAK_MG_W'(MG_PEAK_MAX), "milli-g peak out of range")
   `ACPT_CHECK_NOW(a_troughs_nonpositive, clock, reset, rsp_valid,
      (rsp_data.trough_x <= 0) && (rsp_data.trough_y <= 0) && (rsp_data.trough_z <= 0),
      "trough above zero")

endmodule
